[design/srfw_pkg.sv]
// Shared definitions for the solid rectangle fill writer.
// Holds register indexes, pixel format codes, field widths and color helpers.
// No dependencies.
package srfw_pkg;

  localparam int unsigned MAX_DIM_DEF   = 4096;
  localparam int unsigned ADDR_BITS_DEF = 32;

  localparam int unsigned DIM_FIELD_W  = 13;
  localparam int unsigned CFG_INDEX_W  = 3;
  localparam int unsigned CFG_DATA_W   = 32;
  localparam int unsigned OUT_ADDR_W   = 32;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned STRIDE_W     = 16;
  localparam int unsigned FMT_W        = 4;
  localparam int unsigned BCNT_W       = 3;

  localparam logic [BCNT_W-1:0] BCNT_NONE = 3'd0;
  localparam logic [BCNT_W-1:0] BCNT_16   = 3'd2;
  localparam logic [BCNT_W-1:0] BCNT_24   = 3'd3;
  localparam logic [BCNT_W-1:0] BCNT_32   = 3'd4;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_BASE_ADDRESS   = 3'd0,
    CFG_REGION_WIDTH   = 3'd1,
    CFG_REGION_HEIGHT  = 3'd2,
    CFG_ROW_STRIDE     = 3'd3,
    CFG_PIXEL_FORMAT   = 3'd4,
    CFG_FILL_COLOR     = 3'd5,
    CFG_PREMULTIPLY_EN = 3'd6
  } cfg_index_t;

  typedef enum logic [FMT_W-1:0] {
    FMT_ABGR8888 = 4'd0,
    FMT_XBGR8888 = 4'd1,
    FMT_ARGB8888 = 4'd2,
    FMT_XRGB8888 = 4'd3,
    FMT_RGB888   = 4'd4,
    FMT_BGR888   = 4'd5,
    FMT_RGB565   = 4'd6,
    FMT_RGBA5551 = 4'd7,
    FMT_RGBA4444 = 4'd8
  } pix_fmt_t;

  // Bytes stored per pixel; zero marks a format code that means nothing.
  function automatic logic [BCNT_W-1:0] bytes_per_pixel(input logic [FMT_W-1:0] fmt);
    logic [BCNT_W-1:0] n;
    unique case (fmt)
      FMT_ABGR8888, FMT_XBGR8888, FMT_ARGB8888, FMT_XRGB8888: n = BCNT_32;
      FMT_RGB888, FMT_BGR888:                                  n = BCNT_24;
      FMT_RGB565, FMT_RGBA5551, FMT_RGBA4444:                  n = BCNT_16;
      default:                                                 n = BCNT_NONE;
    endcase
    return n;
  endfunction

  // floor(c * a / 255), exact for any product of two 8-bit values.
  function automatic logic [7:0] scale_by_alpha(input logic [7:0] c, input logic [7:0] a);
    logic [15:0] p;
    logic [16:0] t;
    p = c * a;
    t = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
    return t[15:8];
  endfunction

  function automatic logic [DATA_W-1:0] pack_pixel(input logic [FMT_W-1:0] fmt,
                                                   input logic [7:0] r, input logic [7:0] g,
                                                   input logic [7:0] b, input logic [7:0] a);
    logic [DATA_W-1:0] d;
    unique case (fmt)
      FMT_ABGR8888: d = {a, b, g, r};
      FMT_XBGR8888: d = {8'd0, b, g, r};
      FMT_ARGB8888: d = {a, r, g, b};
      FMT_XRGB8888: d = {8'd0, r, g, b};
      FMT_RGB888:   d = {8'd0, b, g, r};
      FMT_BGR888:   d = {8'd0, r, g, b};
      FMT_RGB565:   d = {16'd0, r[7:3], g[7:2], b[7:3]};
      FMT_RGBA5551: d = {16'd0, r[7:3], g[7:3], b[7:3], |a};
      FMT_RGBA4444: d = {16'd0, r[7:4], g[7:4], b[7:4], a[7:4]};
      default:      d = '0;
    endcase
    return d;
  endfunction

endpackage

[design/solid_rect_fill_writer_unit.sv]
// A result word appears in the cycle after its input word is accepted.
// Throughput: one input word per cycle while the result register is not stalled, each giving at
// most one pixel write; the result register takes a new word in the same cycle that the previous one is taken.
// Reset (rst_n low, synchronous) idles the fill, empties the result register
// and loads the register defaults; premultiply comes up enabled.
// Top level of the solid rectangle fill writer: config registers, walk counters,
// color packing and the result register. Depends on srfw_pkg.
module solid_rect_fill_writer_unit #(
  parameter int unsigned MAX_DIM   = srfw_pkg::MAX_DIM_DEF,
  parameter int unsigned ADDR_BITS = srfw_pkg::ADDR_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,

  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [srfw_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [srfw_pkg::CFG_DATA_W-1:0]      cfg_data,

  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_start_req,

  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_write_valid,
  output logic [srfw_pkg::OUT_ADDR_W-1:0]      out_write_address,
  output logic [srfw_pkg::DATA_W-1:0]          out_write_data,
  output logic [srfw_pkg::BCNT_W-1:0]          out_byte_count,
  output logic                                 out_last_write,
  output logic                                 out_busy_res
);

  localparam int unsigned CNT_W = $clog2(MAX_DIM + 1);
  localparam int unsigned CMP_W = (CNT_W > srfw_pkg::DIM_FIELD_W) ? CNT_W
                                                                  : srfw_pkg::DIM_FIELD_W;
  localparam int unsigned OFF_W = CNT_W + 2;

  // Configuration registers.
  logic [31:0]                          base_r;
  logic [srfw_pkg::DIM_FIELD_W-1:0]     width_r;
  logic [srfw_pkg::DIM_FIELD_W-1:0]     height_r;
  logic [srfw_pkg::STRIDE_W-1:0]        stride_r;
  logic [srfw_pkg::FMT_W-1:0]           fmt_r;
  logic [31:0]                          color_r;
  logic                                 premul_r;

  // Walk state.
  logic [CNT_W-1:0]     col_r, col_nxt;
  logic [CNT_W-1:0]     row_r, row_nxt;
  logic [ADDR_BITS-1:0] row_base_r, row_base_nxt;
  logic                 active_r, active_nxt;

  // Result register.
  logic                              out_valid_r, out_valid_nxt;
  logic                              wr_valid_r, wr_valid_nxt;
  logic [srfw_pkg::OUT_ADDR_W-1:0]   wr_addr_r, wr_addr_nxt;
  logic [srfw_pkg::DATA_W-1:0]       wr_data_r, wr_data_nxt;
  logic [srfw_pkg::BCNT_W-1:0]       bcnt_r, bcnt_nxt;
  logic                              last_r, last_nxt;
  logic                              busy_r, busy_nxt;

  logic                          in_accept;
  logic [CNT_W-1:0]              w_eff, h_eff;
  logic [srfw_pkg::BCNT_W-1:0]   bpp;
  logic [7:0]                    red, green, blue, alpha;
  logic [srfw_pkg::DATA_W-1:0]   pixel;

  logic                 go;
  logic [CNT_W-1:0]     col_s, row_s, col_e, row_e, col_i;
  logic [ADDR_BITS-1:0] rb_s, rb_e, stride_a;
  logic [OFF_W-1:0]     offset;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      width_r  <= '0;
      height_r <= '0;
      stride_r <= '0;
      fmt_r    <= '0;
      color_r  <= '0;
      premul_r <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        srfw_pkg::CFG_BASE_ADDRESS:   base_r   <= cfg_data;
        srfw_pkg::CFG_REGION_WIDTH:   width_r  <= cfg_data[srfw_pkg::DIM_FIELD_W-1:0];
        srfw_pkg::CFG_REGION_HEIGHT:  height_r <= cfg_data[srfw_pkg::DIM_FIELD_W-1:0];
        srfw_pkg::CFG_ROW_STRIDE:     stride_r <= cfg_data[srfw_pkg::STRIDE_W-1:0];
        srfw_pkg::CFG_PIXEL_FORMAT:   fmt_r    <= cfg_data[srfw_pkg::FMT_W-1:0];
        srfw_pkg::CFG_FILL_COLOR:     color_r  <= cfg_data;
        srfw_pkg::CFG_PREMULTIPLY_EN: premul_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Oversized dimensions saturate at MAX_DIM.
  always_comb begin
    w_eff = (CMP_W'(width_r) > CMP_W'(MAX_DIM)) ? CNT_W'(MAX_DIM) : CNT_W'(width_r);
    h_eff = (CMP_W'(height_r) > CMP_W'(MAX_DIM)) ? CNT_W'(MAX_DIM) : CNT_W'(height_r);
  end

  assign bpp      = srfw_pkg::bytes_per_pixel(fmt_r);
  assign stride_a = ADDR_BITS'(stride_r);

  always_comb begin
    alpha = color_r[31:24];
    if (premul_r) begin
      red   = srfw_pkg::scale_by_alpha(color_r[7:0], alpha);
      green = srfw_pkg::scale_by_alpha(color_r[15:8], alpha);
      blue  = srfw_pkg::scale_by_alpha(color_r[23:16], alpha);
    end else begin
      red   = color_r[7:0];
      green = color_r[15:8];
      blue  = color_r[23:16];
    end
    pixel = srfw_pkg::pack_pixel(fmt_r, red, green, blue, alpha);
  end

  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    row_base_nxt = row_base_r;
    active_nxt   = active_r;
    wr_valid_nxt = 1'b0;
    wr_addr_nxt  = '0;
    wr_data_nxt  = '0;
    bcnt_nxt     = srfw_pkg::BCNT_NONE;
    last_nxt     = 1'b0;
    busy_nxt     = 1'b0;

    go    = in_start_req | active_r;
    col_s = in_start_req ? '0 : col_r;
    row_s = in_start_req ? '0 : row_r;
    rb_s  = in_start_req ? ADDR_BITS'(base_r) : row_base_r;

    // A count that already reached a shrunken width closes that row first.
    if (col_s >= w_eff) begin
      col_e = '0;
      row_e = row_s + CNT_W'(1);
      rb_e  = rb_s + stride_a;
    end else begin
      col_e = col_s;
      row_e = row_s;
      rb_e  = rb_s;
    end
    col_i = col_e + CNT_W'(1);

    unique case (bpp)
      srfw_pkg::BCNT_32: offset = {col_e, 2'b00};
      srfw_pkg::BCNT_24: offset = {col_e, 2'b00} - {2'b00, col_e};
      default:           offset = {1'b0, col_e, 1'b0};
    endcase

    if (in_accept && go) begin
      row_base_nxt = rb_s;
      if (bpp == srfw_pkg::BCNT_NONE || w_eff == '0 || h_eff == '0 || row_s >= h_eff) begin
        active_nxt = 1'b0;
        col_nxt    = '0;
        row_nxt    = '0;
      end else if (row_e >= h_eff) begin
        active_nxt   = 1'b0;
        col_nxt      = '0;
        row_nxt      = '0;
        row_base_nxt = rb_e;
      end else begin
        wr_valid_nxt = 1'b1;
        wr_addr_nxt  = srfw_pkg::OUT_ADDR_W'(rb_e + ADDR_BITS'(offset));
        wr_data_nxt  = pixel;
        bcnt_nxt     = bpp;
        active_nxt   = 1'b1;
        if (col_i >= w_eff) begin
          col_nxt      = '0;
          row_base_nxt = rb_e + stride_a;
          if (row_e + CNT_W'(1) >= h_eff) begin
            active_nxt = 1'b0;
            row_nxt    = '0;
            last_nxt   = 1'b1;
          end else begin
            row_nxt = row_e + CNT_W'(1);
          end
        end else begin
          col_nxt      = col_i;
          row_nxt      = row_e;
          row_base_nxt = rb_e;
        end
        busy_nxt = active_nxt;
      end
    end
  end

  assign out_valid_nxt = in_accept | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      row_base_r  <= '0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        col_r      <= col_nxt;
        row_r      <= row_nxt;
        row_base_r <= row_base_nxt;
        active_r   <= active_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      wr_valid_r <= wr_valid_nxt;
      wr_addr_r  <= wr_addr_nxt;
      wr_data_r  <= wr_data_nxt;
      bcnt_r     <= bcnt_nxt;
      last_r     <= last_nxt;
      busy_r     <= busy_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_write_valid   = wr_valid_r;
  assign out_write_address = wr_addr_r;
  assign out_write_data    = wr_data_r;
  assign out_byte_count    = bcnt_r;
  assign out_last_write    = last_r;
  assign out_busy_res      = busy_r;

endmodule

[design/srfw_checker.sv]
// Port-level assertions for the solid rectangle fill writer, bound to its top level.
// Depends on srfw_pkg.
module srfw_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic                             out_write_valid,
  input logic [srfw_pkg::OUT_ADDR_W-1:0]  out_write_address,
  input logic [srfw_pkg::DATA_W-1:0]      out_write_data,
  input logic [srfw_pkg::BCNT_W-1:0]      out_byte_count,
  input logic                             out_last_write,
  input logic                             out_busy_res
);

  // A waiting result word must hold off the next input word.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input accepted while result word is stalled");

  // Every accepted input word yields exactly one result word, valid in the next cycle.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted word produced no result word");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_write_address)
                               && $stable(out_write_data) && $stable(out_write_valid))
    else $error("stalled result word changed");

  // A result without a write carries zeros, and the final write ends the fill.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_write_valid |-> out_write_address == '0 && out_write_data == '0
                                      && out_byte_count == srfw_pkg::BCNT_NONE
                                      && !out_last_write && !out_busy_res)
    else $error("non-write result carries data");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_write |-> out_write_valid && !out_busy_res
                                    && (out_byte_count == srfw_pkg::BCNT_16
                                        || out_byte_count == srfw_pkg::BCNT_24
                                        || out_byte_count == srfw_pkg::BCNT_32))
    else $error("final write malformed");

endmodule

bind solid_rect_fill_writer_unit srfw_checker u_srfw_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_write_valid   (out_write_valid),
  .out_write_address (out_write_address),
  .out_write_data    (out_write_data),
  .out_byte_count    (out_byte_count),
  .out_last_write    (out_last_write),
  .out_busy_res      (out_busy_res)
);

[tb/srfw_write_checker.sv]
// Checker for the solid rectangle fill writer: watches the config, input and result channels,
// predicts every pixel write and compares it with the word the block hands out.
// Depends on srfw_pkg.
`timescale 1ns / 1ps

module srfw_write_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [srfw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [srfw_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic                             in_start_req,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic                             out_write_valid,
  input  logic [srfw_pkg::OUT_ADDR_W-1:0]  out_write_address,
  input  logic [srfw_pkg::DATA_W-1:0]      out_write_data,
  input  logic [srfw_pkg::BCNT_W-1:0]      out_byte_count,
  input  logic                             out_last_write,
  input  logic                             out_busy_res,
  output int                               bad_words,
  output int                               writes_pending
);

  typedef struct packed {
    logic                            wv;
    logic [srfw_pkg::OUT_ADDR_W-1:0] addr;
    logic [srfw_pkg::DATA_W-1:0]     data;
    logic [srfw_pkg::BCNT_W-1:0]     bcnt;
    logic                            last;
    logic                            busy;
  } pixel_write_t;

  // Register copies, written whenever the config channel hands over a word.
  logic [31:0] base_r;
  logic [12:0] width_r;
  logic [12:0] height_r;
  logic [15:0] stride_r;
  logic [3:0]  fmt_r;
  logic [31:0] color_r;
  logic        pm_r;

  // Walk state of the fill.
  int unsigned col;
  int unsigned row;
  logic [31:0] row_base;
  bit          fill_on;

  pixel_write_t expected_writes[$];
  int           n_bad = 0;

  function automatic logic [srfw_pkg::BCNT_W-1:0] format_bytes(input logic [3:0] fmt);
    unique case (fmt)
      srfw_pkg::FMT_ABGR8888, srfw_pkg::FMT_XBGR8888,
      srfw_pkg::FMT_ARGB8888, srfw_pkg::FMT_XRGB8888: return srfw_pkg::BCNT_32;
      srfw_pkg::FMT_RGB888, srfw_pkg::FMT_BGR888:      return srfw_pkg::BCNT_24;
      srfw_pkg::FMT_RGB565, srfw_pkg::FMT_RGBA5551,
      srfw_pkg::FMT_RGBA4444:                          return srfw_pkg::BCNT_16;
      default:                                         return srfw_pkg::BCNT_NONE;
    endcase
  endfunction

  function automatic logic [31:0] fill_pixel();
    int unsigned cr, cg, cb, ca;
    logic [7:0]  r, g, b, a;
    cr = color_r[7:0];
    cg = color_r[15:8];
    cb = color_r[23:16];
    ca = color_r[31:24];
    if (pm_r) begin
      cr = cr * ca / 255;
      cg = cg * ca / 255;
      cb = cb * ca / 255;
    end
    r = 8'(cr);
    g = 8'(cg);
    b = 8'(cb);
    a = 8'(ca);
    unique case (fmt_r)
      srfw_pkg::FMT_ABGR8888: return {a, b, g, r};
      srfw_pkg::FMT_XBGR8888: return {8'd0, b, g, r};
      srfw_pkg::FMT_ARGB8888: return {a, r, g, b};
      srfw_pkg::FMT_XRGB8888: return {8'd0, r, g, b};
      srfw_pkg::FMT_RGB888:   return {8'd0, b, g, r};
      srfw_pkg::FMT_BGR888:   return {8'd0, r, g, b};
      srfw_pkg::FMT_RGB565:   return {16'd0, r[7:3], g[7:2], b[7:3]};
      srfw_pkg::FMT_RGBA5551: return {16'd0, r[7:3], g[7:3], b[7:3], a != 8'd0};
      srfw_pkg::FMT_RGBA4444: return {16'd0, r[7:4], g[7:4], b[7:4], a[7:4]};
      default:                return '0;
    endcase
  endfunction

  // Advances the walk by one input word and returns the pixel write it produces.
  function automatic pixel_write_t next_pixel_write(input logic start);
    pixel_write_t                pw;
    int unsigned                 w, h;
    logic [srfw_pkg::BCNT_W-1:0] bpp;
    w   = (width_r > srfw_pkg::MAX_DIM_DEF) ? srfw_pkg::MAX_DIM_DEF : width_r;
    h   = (height_r > srfw_pkg::MAX_DIM_DEF) ? srfw_pkg::MAX_DIM_DEF : height_r;
    bpp = format_bytes(fmt_r);
    pw  = '0;
    if (start) begin
      fill_on  = 1'b1;
      col      = 0;
      row      = 0;
      row_base = base_r;
    end
    if (!fill_on) return pw;
    if (bpp == srfw_pkg::BCNT_NONE || w == 0 || h == 0 || row >= h) begin
      fill_on = 1'b0;
      col     = 0;
      row     = 0;
      return pw;
    end
    // The width may have shrunk under a running fill; that closes the row.
    if (col >= w) begin
      col      = 0;
      row++;
      row_base = row_base + 32'(stride_r);
      if (row >= h) begin
        fill_on = 1'b0;
        row     = 0;
        return pw;
      end
    end
    pw.wv   = 1'b1;
    pw.addr = row_base + 32'(col) * 32'(bpp);
    pw.data = fill_pixel();
    pw.bcnt = bpp;
    col++;
    if (col >= w) begin
      col      = 0;
      row++;
      row_base = row_base + 32'(stride_r);
      if (row >= h) begin
        fill_on = 1'b0;
        row     = 0;
        pw.last = 1'b1;
      end
    end
    pw.busy = fill_on;
    return pw;
  endfunction

  always @(posedge clk) begin
    pixel_write_t got, want;
    if (!rst_n) begin
      base_r   = '0;
      width_r  = '0;
      height_r = '0;
      stride_r = '0;
      fmt_r    = '0;
      color_r  = '0;
      pm_r     = 1'b1;
      col      = 0;
      row      = 0;
      row_base = '0;
      fill_on  = 1'b0;
      expected_writes.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (srfw_pkg::cfg_index_t'(cfg_index))
          srfw_pkg::CFG_BASE_ADDRESS:   base_r   = cfg_data;
          srfw_pkg::CFG_REGION_WIDTH:   width_r  = cfg_data[12:0];
          srfw_pkg::CFG_REGION_HEIGHT:  height_r = cfg_data[12:0];
          srfw_pkg::CFG_ROW_STRIDE:     stride_r = cfg_data[15:0];
          srfw_pkg::CFG_PIXEL_FORMAT:   fmt_r    = cfg_data[3:0];
          srfw_pkg::CFG_FILL_COLOR:     color_r  = cfg_data;
          srfw_pkg::CFG_PREMULTIPLY_EN: pm_r     = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = '{out_write_valid, out_write_address, out_write_data, out_byte_count,
                out_last_write, out_busy_res};
        if (expected_writes.size() == 0) begin
          if (n_bad < 10)
            $display("unexpected result word: wv=%0b addr=%h data=%h bytes=%0d last=%0b busy=%0b",
                     got.wv, got.addr, got.data, got.bcnt, got.last, got.busy);
          n_bad++;
        end else begin
          want = expected_writes.pop_front();
          if (got !== want) begin
            if (n_bad < 10) begin
              $display("result word mismatch at %0t", $realtime);
              $display("  expected wv=%0b addr=%h data=%h bytes=%0d last=%0b busy=%0b",
                       want.wv, want.addr, want.data, want.bcnt, want.last, want.busy);
              $display("  actual   wv=%0b addr=%h data=%h bytes=%0d last=%0b busy=%0b",
                       got.wv, got.addr, got.data, got.bcnt, got.last, got.busy);
            end
            n_bad++;
          end
        end
      end
      if (in_valid && !in_stall)
        expected_writes.push_back(next_pixel_write(in_start_req));
    end
    bad_words      <= n_bad;
    writes_pending <= expected_writes.size();
  end

endmodule

[tb/tb.sv]
// Top of the fill writer testbench: clock, reset, config writes, start/advance words and
// result-side stalls around solid_rect_fill_writer_unit; srfw_write_checker does the checking.
// Depends on srfw_pkg, srfw_write_checker and the block itself.
`timescale 1ns / 1ps

module tb;

  localparam int          CYCLE_LIMIT  = 400_000;
  localparam logic [3:0]  FMT_BAD_LOW  = 4'd9;
  localparam logic [3:0]  FMT_BAD_HIGH = 4'hF;

  logic                             clk;
  logic                             rst_n;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [srfw_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [srfw_pkg::CFG_DATA_W-1:0]  cfg_data;
  logic                             in_valid;
  logic                             in_stall;
  logic                             in_start_req;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic                             out_write_valid;
  logic [srfw_pkg::OUT_ADDR_W-1:0]  out_write_address;
  logic [srfw_pkg::DATA_W-1:0]      out_write_data;
  logic [srfw_pkg::BCNT_W-1:0]      out_byte_count;
  logic                             out_last_write;
  logic                             out_busy_res;

  int bad_words;
  int writes_pending;
  int cycles      = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit rx_hold     = 1'b0;
  bit hold_go     = 1'b0;

  solid_rect_fill_writer_unit uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_start_req      (in_start_req),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_write_valid   (out_write_valid),
    .out_write_address (out_write_address),
    .out_write_data    (out_write_data),
    .out_byte_count    (out_byte_count),
    .out_last_write    (out_last_write),
    .out_busy_res      (out_busy_res)
  );

  srfw_write_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_start_req      (in_start_req),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_write_valid   (out_write_valid),
    .out_write_address (out_write_address),
    .out_write_data    (out_write_data),
    .out_byte_count    (out_byte_count),
    .out_last_write    (out_last_write),
    .out_busy_res      (out_busy_res),
    .bad_words         (bad_words),
    .writes_pending    (writes_pending)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= rx_hold || ($urandom_range(0, 99) < rx_idle_pct);
  end

  // One long hold on the result side while the sender keeps offering words.
  initial begin
    wait (hold_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (150) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Leaves cfg_valid high so back-to-back writes never drop it within one step.
  task automatic write_reg(input srfw_pkg::cfg_index_t idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic poke(input srfw_pkg::cfg_index_t idx, input logic [31:0] val);
    write_reg(idx, val);
    cfg_valid <= 1'b0;
  endtask

  task automatic setup_fill(input logic [31:0] base, input int w, input int h,
                            input int stride, input int fmt, input logic [31:0] color,
                            input bit pm);
    write_reg(srfw_pkg::CFG_BASE_ADDRESS, base);
    write_reg(srfw_pkg::CFG_REGION_WIDTH, 32'(w));
    write_reg(srfw_pkg::CFG_REGION_HEIGHT, 32'(h));
    write_reg(srfw_pkg::CFG_ROW_STRIDE, 32'(stride));
    write_reg(srfw_pkg::CFG_PIXEL_FORMAT, 32'(fmt));
    write_reg(srfw_pkg::CFG_FILL_COLOR, color);
    write_reg(srfw_pkg::CFG_PREMULTIPLY_EN, 32'(pm));
    cfg_valid <= 1'b0;
  endtask

  task automatic send_word(input logic start);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_start_req <= start;
    do @(posedge clk); while (in_stall);
  endtask

  // Waits until every predicted word has come back and the block has gone quiet.
  task automatic settle;
    in_valid <= 1'b0;
    do @(posedge clk); while (writes_pending != 0);
    repeat (2) @(posedge clk);
  endtask

  function automatic int pick_dim();
    int sel;
    sel = $urandom_range(0, 15);
    if (sel == 0) return 0;
    if (sel == 1) return $urandom_range(0, 8191);
    return $urandom_range(1, 6);
  endfunction

  task automatic run_phase(input int tx_pct, input int rx_pct, input int n_words);
    int                   sent, w, h, npix, span, tail, k;
    srfw_pkg::cfg_index_t idx;
    tx_idle_pct <= tx_pct;
    rx_idle_pct <= rx_pct;
    sent = 0;
    while (sent < n_words) begin
      w = pick_dim();
      h = pick_dim();
      settle;
      setup_fill($urandom, w, h, $urandom_range(0, 65535),
                 ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                             : $urandom_range(0, srfw_pkg::FMT_RGBA4444),
                 $urandom, $urandom_range(0, 1));
      npix = ((w > srfw_pkg::MAX_DIM_DEF) ? srfw_pkg::MAX_DIM_DEF : w)
             * ((h > srfw_pkg::MAX_DIM_DEF) ? srfw_pkg::MAX_DIM_DEF : h);
      // Large regions are only walked a little way before the next setup.
      span = (npix > 40) ? $urandom_range(3, 20) : ((npix == 0) ? 1 : npix);
      tail = span + $urandom_range(0, 2);
      send_word(1'b1);
      for (k = 1; k < tail; k++) begin
        if (k == span / 2 && $urandom_range(0, 7) == 0) begin
          settle;
          idx = srfw_pkg::cfg_index_t'($urandom_range(0, srfw_pkg::CFG_PREMULTIPLY_EN));
          poke(idx, (idx == srfw_pkg::CFG_REGION_WIDTH || idx == srfw_pkg::CFG_REGION_HEIGHT) ?
                    32'($urandom_range(0, 6)) : $urandom);
        end
        send_word($urandom_range(0, 39) == 0);
      end
      sent += span;
    end
    settle;
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    in_start_req = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Advance while idle, then a start on the empty region left by reset.
    send_word(1'b0);
    send_word(1'b1);
    settle;

    // Two rows that wrap past the top of the address space, then one word past the end.
    setup_fill(32'hFFFF_FFF8, 3, 2, 16'hFFFF, srfw_pkg::FMT_ABGR8888, 32'h80FF_4020, 1'b1);
    send_word(1'b1);
    repeat (6) send_word(1'b0);
    settle;

    // Oversized dimensions with invalid formats finish at once.
    setup_fill(32'h0, 8191, 8191, 0, FMT_BAD_HIGH, 32'hFFFF_FFFF, 1'b0);
    send_word(1'b1);
    settle;
    poke(srfw_pkg::CFG_PIXEL_FORMAT, 32'(FMT_BAD_LOW));
    send_word(1'b1);
    settle;

    // Restart during a fill, then a width of zero ends the fill in progress.
    poke(srfw_pkg::CFG_PIXEL_FORMAT, 32'(srfw_pkg::FMT_RGBA5551));
    send_word(1'b1);
    send_word(1'b0);
    send_word(1'b0);
    send_word(1'b1);
    send_word(1'b0);
    settle;
    poke(srfw_pkg::CFG_REGION_WIDTH, 32'd0);
    send_word(1'b0);
    send_word(1'b0);
    settle;

    setup_fill(32'h0000_1000, 2, 0, 16'h0040, srfw_pkg::FMT_RGB565, 32'h00FF_FFFF, 1'b1);
    send_word(1'b1);
    settle;

    // The width shrinks under a running fill; the current row closes early.
    setup_fill(32'h0000_1000, 5, 2, 16'h0040, srfw_pkg::FMT_RGB565, 32'h00FF_FFFF, 1'b1);
    send_word(1'b1);
    repeat (3) send_word(1'b0);
    settle;
    poke(srfw_pkg::CFG_REGION_WIDTH, 32'd2);
    repeat (2) send_word(1'b0);
    settle;

    run_phase(37, 61, 270);
    run_phase(61, 37, 270);
    hold_go <= 1'b1;
    run_phase(0, 0, 270);

    // Width and height above the maximum saturate; each fill is walked a short way.
    setup_fill($urandom, 8191, 1, $urandom_range(0, 65535), srfw_pkg::FMT_XRGB8888,
               $urandom, 1'b1);
    send_word(1'b1);
    repeat (20) send_word(1'b0);
    settle;
    setup_fill($urandom, 1, 8191, 16'hFFFF, srfw_pkg::FMT_BGR888, $urandom, 1'b0);
    send_word(1'b1);
    repeat (20) send_word(1'b0);
    settle;

    repeat (4) @(posedge clk);
    if (bad_words == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[filelist.f]
design/srfw_pkg.sv
design/solid_rect_fill_writer_unit.sv
design/srfw_checker.sv
tb/srfw_write_checker.sv
tb/tb.sv
